>>> rtl/mbs_pkg.sv
// Package for the multipart boundary splitter: types, constants and symbol helpers.
package mbs_pkg;

    localparam int MAX_BOUNDARY = 56;

    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_DASH = 8'h2D;
    localparam logic [31:0] HDR_END = 32'h0D0A_0D0A;

    localparam logic [1:0] MODE_OPEN   = 2'd0;
    localparam logic [1:0] MODE_HEADER = 2'd1;
    localparam logic [1:0] MODE_BODY   = 2'd2;
    localparam logic [1:0] MODE_DONE   = 2'd3;

    localparam logic [2:0] KIND_PART_START = 3'd0;
    localparam logic [2:0] KIND_HDR_BYTE   = 3'd1;
    localparam logic [2:0] KIND_HDR_END    = 3'd2;
    localparam logic [2:0] KIND_BODY_BYTE  = 3'd3;
    localparam logic [2:0] KIND_PART_END   = 3'd4;
    localparam logic [2:0] KIND_COMPLETE   = 3'd5;

    localparam logic ACT_WRITE_BOUNDARY = 1'b0;
    localparam logic ACT_STREAM_BYTE    = 1'b1;

    localparam logic REG_BOUNDARY_LEN = 1'b0;

    typedef logic [6:0] idx_t;

    typedef struct packed {
        logic       action;
        logic [7:0] byte_value;
        logic [5:0] boundary_index;
        logic       chunk_last;
    } in_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] out_byte;
        logic       last;
    } out_t;

    // Where one pattern symbol comes from: a constant byte or a boundary store entry.
    typedef struct packed {
        logic       st;
        logic [7:0] cb;
        logic [5:0] si;
    } src_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOOK,
        ST_CHK,
        ST_FB_INIT,
        ST_FB_ADDR,
        ST_FB_CMP,
        ST_FB_DONE,
        ST_EM_ADDR,
        ST_EM_PUT,
        ST_PUT1,
        ST_PUT2
    } state_t;

    function automatic src_t store_src(idx_t i);
        src_t r;
        r.st = (i < idx_t'(MAX_BOUNDARY));
        r.cb = 8'h00;
        r.si = r.st ? i[5:0] : 6'd0;
        return r;
    endfunction

    // Symbol i of the opening line or of the body delimiter.
    function automatic src_t sym_src(logic opening, idx_t i, idx_t b);
        src_t r;
        r = '{st: 1'b0, cb: 8'h00, si: 6'd0};
        if (opening) begin
            if (i < idx_t'(2)) r.cb = CH_DASH;
            else if (i < b + idx_t'(2)) r = store_src(i - idx_t'(2));
            else if (i == b + idx_t'(2)) r.cb = CH_CR;
            else r.cb = CH_LF;
        end else begin
            if (i == idx_t'(0)) r.cb = CH_CR;
            else if (i == idx_t'(1)) r.cb = CH_LF;
            else if (i < idx_t'(4)) r.cb = CH_DASH;
            else r = store_src(i - idx_t'(4));
        end
        return r;
    endfunction

endpackage

>>> rtl/multipart_boundary_splitter.sv
// Multipart boundary splitter: byte-serial parser with a shared compare sequencer.
// One request is taken at a time. A boundary write, the first suffix byte after a full
// delimiter and a byte after the stream has completed are handled in the idle state. A byte
// that extends a match passes through a store lookup and a compare (ST_LOOK, ST_CHK), and
// also an output put when it completes the opening line. A header byte is put out in ST_PUT1,
// followed by ST_PUT2 when it ends the headers, and a confirmed delimiter uses both. A failed
// match runs a prefix fallback search through one shared byte comparator, each compare
// being a registered store read, then the compare, over the pattern (the boundary plus
// four symbols); each released body byte then takes an address step and a put. Each result
// leaves through a single output register, so every result can wait further on m_ready.
module multipart_boundary_splitter (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  mbs_pkg::in_t        s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output mbs_pkg::out_t       m_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic                paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    mbs_pkg::state_t state_reg, state_next;
    logic [1:0]  mode_reg, mode_next;
    logic [5:0]  m_reg, m_next;
    logic        suf_v_reg, suf_v_next;
    logic [7:0]  suf_b_reg, suf_b_next;
    logic [31:0] ht_reg, ht_next;
    logic [5:0]  blen_reg;
    logic [7:0]  c_reg, c_next;
    mbs_pkg::idx_t m0_reg, m0_next, n_reg, n_next, k_reg, k_next, j_reg, j_next;
    logic [7:0]  e0_reg, e0_next, e1_reg, e1_next;
    logic [2:0]  p1_kind_reg, p1_kind_next, p2_kind_reg, p2_kind_next;
    logic [7:0]  p1_byte_reg, p1_byte_next;
    logic        p2_has_reg, p2_has_next;
    logic        m_valid_reg, m_valid_next;
    mbs_pkg::out_t m_data_reg, m_data_next;

    logic [7:0]  store_mem [mbs_pkg::MAX_BOUNDARY];
    logic [7:0]  rd_a_reg, rd_b_reg;
    logic        a_st_reg, b_st_reg;
    logic [7:0]  a_cb_reg, b_cb_reg;
    mbs_pkg::src_t src_a, src_b;

    mbs_pkg::idx_t b_eff, total, a_idx, k_init;
    mbs_pkg::idx_t m_ext;
    logic        opening, cfg_wr, s_acc, slot_free;
    logic [7:0]  byte_a, byte_b;
    logic [31:0] ht_shift;

    assign pready  = 1'b1;
    assign prdata  = {26'd0, blen_reg};
    assign cfg_wr  = psel && penable && pwrite && (paddr == mbs_pkg::REG_BOUNDARY_LEN);
    assign s_ready = (state_reg == mbs_pkg::ST_IDLE);
    assign s_acc   = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
    assign slot_free = !m_valid_reg || m_ready;

    assign b_eff = (blen_reg == 6'd0) ? mbs_pkg::idx_t'(1) :
                   (blen_reg > 6'(mbs_pkg::MAX_BOUNDARY)) ? mbs_pkg::idx_t'(mbs_pkg::MAX_BOUNDARY) :
                   mbs_pkg::idx_t'(blen_reg);
    assign total   = b_eff + mbs_pkg::idx_t'(4);
    assign opening = (mode_reg == mbs_pkg::MODE_OPEN);
    assign m_ext   = mbs_pkg::idx_t'(m_reg);
    assign k_init  = ((n_reg - mbs_pkg::idx_t'(1)) > total) ? total : (n_reg - mbs_pkg::idx_t'(1));
    assign byte_a  = a_st_reg ? rd_a_reg : a_cb_reg;
    assign byte_b  = b_st_reg ? rd_b_reg : b_cb_reg;
    assign ht_shift = {ht_reg[23:0], s_data.byte_value};

    // Port A reads the held stream sequence (or the pattern when looking up one symbol),
    // port B the pattern symbol it is compared against. While a released byte waits for the
    // output slot, port A keeps reading the same entry.
    always_comb begin
        priority if (state_reg == mbs_pkg::ST_LOOK) begin
            a_idx = m_ext;
        end else if (state_reg == mbs_pkg::ST_EM_ADDR || state_reg == mbs_pkg::ST_EM_PUT) begin
            a_idx = j_reg;
        end else begin
            a_idx = n_reg - k_reg + j_reg;
        end
        if (state_reg == mbs_pkg::ST_LOOK || a_idx < m0_reg) begin
            src_a = mbs_pkg::sym_src(opening, a_idx, b_eff);
        end else begin
            src_a = '{st: 1'b0, cb: (a_idx == m0_reg) ? e0_reg : e1_reg, si: 6'd0};
        end
        src_b = mbs_pkg::sym_src(opening, j_reg, b_eff);
    end

    always_ff @(posedge aclk) begin
        if (s_acc && s_data.action == mbs_pkg::ACT_WRITE_BOUNDARY &&
            s_data.boundary_index < 6'(mbs_pkg::MAX_BOUNDARY)) begin
            store_mem[s_data.boundary_index] <= s_data.byte_value;
        end
        rd_a_reg <= store_mem[src_a.si];
        rd_b_reg <= store_mem[src_b.si];
        a_st_reg <= src_a.st;
        a_cb_reg <= src_a.cb;
        b_st_reg <= src_b.st;
        b_cb_reg <= src_b.cb;
    end

    always_comb begin
        state_next   = state_reg;
        mode_next    = mode_reg;
        m_next       = m_reg;
        suf_v_next   = suf_v_reg;
        suf_b_next   = suf_b_reg;
        ht_next      = ht_reg;
        c_next       = c_reg;
        m0_next      = m0_reg;
        n_next       = n_reg;
        k_next       = k_reg;
        j_next       = j_reg;
        e0_next      = e0_reg;
        e1_next      = e1_reg;
        p1_kind_next = p1_kind_reg;
        p1_byte_next = p1_byte_reg;
        p2_kind_next = p2_kind_reg;
        p2_has_next  = p2_has_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;

        unique case (state_reg)
            mbs_pkg::ST_IDLE: begin
                if (s_acc && s_data.action == mbs_pkg::ACT_STREAM_BYTE) begin
                    c_next = s_data.byte_value;
                    unique case (mode_reg)
                        mbs_pkg::MODE_OPEN: begin
                            if (m_ext >= total) m_next = 6'd0;
                            state_next = mbs_pkg::ST_LOOK;
                        end
                        mbs_pkg::MODE_HEADER: begin
                            p1_kind_next = mbs_pkg::KIND_HDR_BYTE;
                            p1_byte_next = s_data.byte_value;
                            p2_kind_next = mbs_pkg::KIND_HDR_END;
                            state_next   = mbs_pkg::ST_PUT1;
                            if (ht_shift == mbs_pkg::HDR_END) begin
                                p2_has_next = 1'b1;
                                mode_next   = mbs_pkg::MODE_BODY;
                                m_next      = 6'd0;
                                suf_v_next  = 1'b0;
                                ht_next     = 32'd0;
                            end else begin
                                p2_has_next = 1'b0;
                                ht_next     = ht_shift;
                            end
                        end
                        mbs_pkg::MODE_BODY: begin
                            if (m_ext > total) begin
                                m_next     = 6'd0;
                                suf_v_next = 1'b0;
                                state_next = mbs_pkg::ST_LOOK;
                            end else if (m_ext < total) begin
                                state_next = mbs_pkg::ST_LOOK;
                            end else if (!suf_v_reg) begin
                                suf_v_next = 1'b1;
                                suf_b_next = s_data.byte_value;
                            end else if ((suf_b_reg == mbs_pkg::CH_DASH &&
                                          s_data.byte_value == mbs_pkg::CH_DASH) ||
                                         (suf_b_reg == mbs_pkg::CH_CR &&
                                          s_data.byte_value == mbs_pkg::CH_LF)) begin
                                p1_kind_next = mbs_pkg::KIND_PART_END;
                                p1_byte_next = 8'd0;
                                p2_has_next  = 1'b1;
                                m_next       = 6'd0;
                                suf_v_next   = 1'b0;
                                state_next   = mbs_pkg::ST_PUT1;
                                if (suf_b_reg == mbs_pkg::CH_DASH) begin
                                    p2_kind_next = mbs_pkg::KIND_COMPLETE;
                                    mode_next    = mbs_pkg::MODE_DONE;
                                end else begin
                                    p2_kind_next = mbs_pkg::KIND_PART_START;
                                    mode_next    = mbs_pkg::MODE_HEADER;
                                    ht_next      = 32'd0;
                                end
                            end else begin
                                // Whole delimiter plus both suffix bytes fall back.
                                m0_next    = total;
                                e0_next    = suf_b_reg;
                                e1_next    = s_data.byte_value;
                                n_next     = total + mbs_pkg::idx_t'(2);
                                state_next = mbs_pkg::ST_FB_INIT;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            mbs_pkg::ST_LOOK: begin
                state_next = mbs_pkg::ST_CHK;
            end
            mbs_pkg::ST_CHK: begin
                if (byte_a == c_reg) begin
                    if (opening) begin
                        if (m_ext + mbs_pkg::idx_t'(1) == total) begin
                            p1_kind_next = mbs_pkg::KIND_PART_START;
                            p1_byte_next = 8'd0;
                            p2_has_next  = 1'b0;
                            mode_next    = mbs_pkg::MODE_HEADER;
                            ht_next      = 32'd0;
                            m_next       = 6'd0;
                            state_next   = mbs_pkg::ST_PUT1;
                        end else begin
                            m_next     = m_reg + 6'd1;
                            state_next = mbs_pkg::ST_IDLE;
                        end
                    end else begin
                        m_next     = m_reg + 6'd1;
                        suf_v_next = 1'b0;
                        state_next = mbs_pkg::ST_IDLE;
                    end
                end else begin
                    m0_next    = m_ext;
                    e0_next    = c_reg;
                    e1_next    = c_reg;
                    n_next     = m_ext + mbs_pkg::idx_t'(1);
                    state_next = mbs_pkg::ST_FB_INIT;
                end
            end
            mbs_pkg::ST_FB_INIT: begin
                k_next     = k_init;
                j_next     = '0;
                state_next = (k_init == '0) ? mbs_pkg::ST_FB_DONE : mbs_pkg::ST_FB_ADDR;
            end
            mbs_pkg::ST_FB_ADDR: begin
                state_next = mbs_pkg::ST_FB_CMP;
            end
            mbs_pkg::ST_FB_CMP: begin
                if (byte_a != byte_b) begin
                    k_next     = k_reg - mbs_pkg::idx_t'(1);
                    j_next     = '0;
                    state_next = (k_reg == mbs_pkg::idx_t'(1)) ? mbs_pkg::ST_FB_DONE
                                                               : mbs_pkg::ST_FB_ADDR;
                end else if (j_reg + mbs_pkg::idx_t'(1) == k_reg) begin
                    state_next = mbs_pkg::ST_FB_DONE;
                end else begin
                    j_next     = j_reg + mbs_pkg::idx_t'(1);
                    state_next = mbs_pkg::ST_FB_ADDR;
                end
            end
            mbs_pkg::ST_FB_DONE: begin
                if (opening) begin
                    m_next     = k_reg[5:0];
                    state_next = mbs_pkg::ST_IDLE;
                end else begin
                    j_next     = '0;
                    state_next = mbs_pkg::ST_EM_ADDR;
                end
            end
            mbs_pkg::ST_EM_ADDR: begin
                state_next = mbs_pkg::ST_EM_PUT;
            end
            mbs_pkg::ST_EM_PUT: begin
                if (slot_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '{kind: mbs_pkg::KIND_BODY_BYTE, out_byte: byte_a,
                                     last: (j_reg + k_reg + mbs_pkg::idx_t'(1) == n_reg)};
                    if (j_reg + k_reg + mbs_pkg::idx_t'(1) == n_reg) begin
                        m_next     = k_reg[5:0];
                        suf_v_next = 1'b0;
                        state_next = mbs_pkg::ST_IDLE;
                    end else begin
                        j_next     = j_reg + mbs_pkg::idx_t'(1);
                        state_next = mbs_pkg::ST_EM_ADDR;
                    end
                end
            end
            mbs_pkg::ST_PUT1: begin
                if (slot_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '{kind: p1_kind_reg, out_byte: p1_byte_reg,
                                     last: !p2_has_reg};
                    state_next   = p2_has_reg ? mbs_pkg::ST_PUT2 : mbs_pkg::ST_IDLE;
                end
            end
            mbs_pkg::ST_PUT2: begin
                if (slot_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '{kind: p2_kind_reg, out_byte: 8'd0, last: 1'b1};
                    state_next   = mbs_pkg::ST_IDLE;
                end
            end
            default: state_next = mbs_pkg::ST_IDLE;
        endcase

        // A length write drops any partial match.
        if (cfg_wr) begin
            m_next     = 6'd0;
            suf_v_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= mbs_pkg::ST_IDLE;
            mode_reg    <= mbs_pkg::MODE_OPEN;
            m_reg       <= 6'd0;
            suf_v_reg   <= 1'b0;
            ht_reg      <= 32'd0;
            blen_reg    <= 6'd1;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            mode_reg    <= mode_next;
            m_reg       <= m_next;
            suf_v_reg   <= suf_v_next;
            ht_reg      <= ht_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr) blen_reg <= pwdata[5:0];
        end
    end

    always_ff @(posedge aclk) begin
        suf_b_reg   <= suf_b_next;
        c_reg       <= c_next;
        m0_reg      <= m0_next;
        n_reg       <= n_next;
        k_reg       <= k_next;
        j_reg       <= j_next;
        e0_reg      <= e0_next;
        e1_reg      <= e1_next;
        p1_kind_reg <= p1_kind_next;
        p1_byte_reg <= p1_byte_next;
        p2_kind_reg <= p2_kind_next;
        p2_has_reg  <= p2_has_next;
        m_data_reg  <= m_data_next;
    end

endmodule
